// File: hdl/rgb_to_led_palette_quantizer_defines.svh
// Assertion macros used by the palette quantizer top level.
`ifndef RGB_TO_LED_PALETTE_QUANTIZER_DEFINES_SVH
`define RGB_TO_LED_PALETTE_QUANTIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rlpq_pkg.sv
// Package with widths and decision thresholds of the palette quantizer.
`timescale 1ns / 1ps
`default_nettype none

package rlpq_pkg;

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pixel_t;

  localparam chan_t LOW_CUT      = 8'd25;
  localparam int    BRIGHT_CUT   = 175;
  localparam int    MEAN_BIAS    = 10;
  localparam chan_t LVL_TOP      = 8'd220;
  localparam chan_t LVL_HIGH     = 8'd165;
  localparam chan_t LVL_MID      = 8'd110;
  localparam chan_t LVL_LOW      = 8'd57;
  localparam chan_t MIX_CUT      = 8'd135;
  localparam chan_t RED_BLUE_CUT = 8'd85;
  localparam int    NEAR_DIFF    = 20;
  localparam pixel_t WHITE_24    = 24'hFFFFFF;
  localparam pixel_t BLACK_24    = 24'h000000;

endpackage

`default_nettype wire

// File: hdl/rlpq_map.sv
// Combinational decision tree that maps one RGB pixel to an LED color.
`timescale 1ns / 1ps
`default_nettype none

module rlpq_map (
  input  wire rlpq_pkg::pixel_t pixel,
  output rlpq_pkg::pixel_t      color
);
  import rlpq_pkg::*;

  // Sum of the channels plus bias; the truncated mean exceeds the bright cut
  // exactly when this sum reaches three times one more than the cut.
  localparam int SUM_W = CH_W + 2;
  localparam logic [SUM_W-1:0] BRIGHT_SUM = SUM_W'(3 * (BRIGHT_CUT + 1));
  localparam logic signed [CH_W:0] NEAR_S = (CH_W+1)'(NEAR_DIFF);

  function automatic chan_t quant(input chan_t v);
    chan_t q;
    if (v > LVL_TOP) begin
      q = LVL_TOP;
    end else if (v > LVL_HIGH) begin
      q = LVL_HIGH;
    end else if (v > LVL_MID) begin
      q = LVL_MID;
    end else begin
      q = LVL_LOW;
    end
    return q;
  endfunction

  chan_t r, g, b;
  logic [SUM_W-1:0] sum;
  logic signed [CH_W:0] d_rb, d_rg, d_gr, d_gb;
  logic near_rb, near_rg, near_gr, near_gb;

  assign r = pixel[PIX_W-1 -: CH_W];
  assign g = pixel[2*CH_W-1 -: CH_W];
  assign b = pixel[CH_W-1:0];

  assign sum = SUM_W'(r) + SUM_W'(g) + SUM_W'(b) + SUM_W'(MEAN_BIAS);

  // Differences are signed, so a negative difference counts as near.
  assign d_rb = $signed({1'b0, r}) - $signed({1'b0, b});
  assign d_rg = $signed({1'b0, r}) - $signed({1'b0, g});
  assign d_gr = $signed({1'b0, g}) - $signed({1'b0, r});
  assign d_gb = $signed({1'b0, g}) - $signed({1'b0, b});
  assign near_rb = d_rb < NEAR_S;
  assign near_rg = d_rg < NEAR_S;
  assign near_gr = d_gr < NEAR_S;
  assign near_gb = d_gb < NEAR_S;

  always_comb begin
    color = BLACK_24;
    priority if (r < LOW_CUT && g < LOW_CUT && b < LOW_CUT) begin
      color = BLACK_24;
    end else if (sum >= BRIGHT_SUM) begin
      color = WHITE_24;
    end else if (r != '0) begin
      if (g != '0) begin
        priority if (b == '0) begin
          color = BLACK_24;
        end else if (b > r && b > g) begin
          priority if (g > r) begin
            color = {8'h00, g, b};
          end else if ((r > RED_BLUE_CUT) ^ near_rb) begin
            color = {r, 8'h00, b};
          end else begin
            color = {8'h00, 8'h00, quant(b)};
          end
        end else if (r > b && r > g) begin
          if (g > b) begin
            if ((g >= MIX_CUT) ^ near_rg) begin
              color = {r, g, 8'h00};
            end else begin
              color = {quant(r), 8'h00, 8'h00};
            end
          end else begin
            if ((b >= MIX_CUT) ^ near_rb) begin
              color = {r, 8'h00, b};
            end else begin
              color = {quant(r), 8'h00, 8'h00};
            end
          end
        end else if (r > b) begin
          // Green ties or leads here.
          if ((r >= MIX_CUT) ^ near_gr) begin
            color = {r, g, 8'h00};
          end else begin
            color = {8'h00, quant(g), 8'h00};
          end
        end else begin
          if ((b >= MIX_CUT) ^ near_gb) begin
            color = {8'h00, g, b};
          end else begin
            color = {8'h00, quant(g), 8'h00};
          end
        end
      end else if (b != '0) begin
        // Purple: red and blue with no green use fixed codes.
        if (r > b) begin
          color = {quant(r), LVL_LOW, 8'h00};
        end else begin
          color = {LVL_LOW, quant(b), 8'h00};
        end
      end else begin
        color = {quant(r), 8'h00, 8'h00};
      end
    end else if (b != '0) begin
      if (g != '0) begin
        color = {8'h00, g, b};
      end else begin
        color = {8'h00, 8'h00, quant(b)};
      end
    end else if (g != '0) begin
      color = {8'h00, quant(g), 8'h00};
    end else begin
      color = BLACK_24;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rgb_to_led_palette_quantizer.sv
// Top level: input register, palette decision tree and result register.
// Requests pass through the input register and then the result register.
// Throughput: one pixel per clock while out_ready keeps up; the input and
// result registers, a two-stage pipeline, stall together only when both are full.
// Reset: synchronous active-low rst_n clears both stage valid flags; the
// pixel and color registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_led_palette_quantizer (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire rlpq_pkg::pixel_t in_pixel_in,
  output logic                  out_valid,
  input  wire                   out_ready,
  output rlpq_pkg::pixel_t      out_led_color
);
  import rlpq_pkg::*;

  `include "rgb_to_led_palette_quantizer_defines.svh"

  logic   s1_v_r, s1_v_nxt;
  pixel_t s1_pix_r;
  logic   s2_v_r, s2_v_nxt;
  pixel_t s2_color_r;
  pixel_t map_color;
  logic   s2_free, s1_adv, in_acc;

  rlpq_map u_map (
    .pixel (s1_pix_r),
    .color (map_color)
  );

  assign s2_free  = !s2_v_r || out_ready;
  assign s1_adv   = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_ready) begin
      s1_v_nxt = in_valid;
    end
    s2_v_nxt = s2_v_r;
    if (s2_free) begin
      s2_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_pixel_in;
    end
    if (s1_adv) begin
      s2_color_r <= map_color;
    end
  end

  assign out_valid     = s2_v_r;
  assign out_led_color = s2_color_r;

  `RLPQ_ASSERT_NOW(a_stall_only_full, !in_ready, s1_v_r && s2_v_r,
    "input stalled while a pipeline stage is empty")
  `RLPQ_ASSERT_NEXT(a_result_follows, s1_adv, out_valid && out_led_color == $past(map_color),
    "result register does not hold the mapped color of the advanced request")
  `RLPQ_ASSERT_NOW(a_dark_black,
    s1_v_r && s1_pix_r[23:16] < LOW_CUT && s1_pix_r[15:8] < LOW_CUT && s1_pix_r[7:0] < LOW_CUT,
    map_color == BLACK_24, "near-black pixel did not map to black")
  `RLPQ_ASSERT_NEXT(a_accept_fills, in_acc, s1_v_r && s1_pix_r == $past(in_pixel_in),
    "accepted request not captured in the input register")

endmodule

`default_nettype wire

// File: tb/tb_rgb_to_led_palette_quantizer.sv
// Self-checking testbench for the RGB to LED palette quantizer.
`timescale 1ns / 1ps
`default_nettype none

module tb_rgb_to_led_palette_quantizer;
  import rlpq_pkg::*;

  localparam int DARK_LIM  = 25;
  localparam int BRIGHT    = 175;
  localparam int BIAS      = 10;
  localparam int Q_TOP     = 220;
  localparam int Q_HIGH    = 165;
  localparam int Q_MID     = 110;
  localparam int Q_LOW     = 57;
  localparam int MIX_LIM   = 135;
  localparam int CLOSE_LIM = 20;
  localparam int RB_LIM    = 85;
  localparam int RAND_PER_PHASE = 400;

  class palette_scoreboard;
    pixel_t pending_colors[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    static function chan_t quant_level(int v);
      if (v > Q_TOP) return chan_t'(Q_TOP);
      if (v > Q_HIGH) return chan_t'(Q_HIGH);
      if (v > Q_MID) return chan_t'(Q_MID);
      return chan_t'(Q_LOW);
    endfunction

    static function pixel_t purple_color(int r, int b);
      if (r > b) begin
        if (r > Q_TOP) return 24'hDC3900;
        if (r > Q_HIGH) return 24'hA53900;
        if (r > Q_MID) return 24'h6E3900;
        return 24'h393900;
      end
      if (b > Q_TOP) return 24'h39DC00;
      if (b > Q_HIGH) return 24'h39A500;
      if (b > Q_MID) return 24'h396E00;
      return 24'h393900;
    endfunction

    static function pixel_t palette_color(pixel_t px);
      int r, g, b;
      r = int'(px[23:16]);
      g = int'(px[15:8]);
      b = int'(px[7:0]);
      if (r < DARK_LIM && g < DARK_LIM && b < DARK_LIM) return BLACK_24;
      if ((r + g + b + BIAS) / 3 > BRIGHT) return WHITE_24;
      if (r > 0) begin
        if (g > 0) begin
          // Red and green present without blue is black, as in rlpq_map.
          if (b == 0) return BLACK_24;
          if (b > r && b > g) begin
            if (g > r) return {8'h00, chan_t'(g), chan_t'(b)};
            if ((r > RB_LIM) != ((r - b) < CLOSE_LIM)) return {chan_t'(r), 8'h00, chan_t'(b)};
            return {16'h0000, quant_level(b)};
          end
          if (r > b && r > g) begin
            if (g > b) begin
              if ((g >= MIX_LIM) != ((r - g) < CLOSE_LIM))
                return {chan_t'(r), chan_t'(g), 8'h00};
              return {quant_level(r), 16'h0000};
            end
            if ((b >= MIX_LIM) != ((r - b) < CLOSE_LIM)) return {chan_t'(r), 8'h00, chan_t'(b)};
            return {quant_level(r), 16'h0000};
          end
          // Cases where neither red nor blue is strictly largest land in the green branch.
          if (r > b) begin
            if ((r >= MIX_LIM) != ((g - r) < CLOSE_LIM)) return {chan_t'(r), chan_t'(g), 8'h00};
            return {8'h00, quant_level(g), 8'h00};
          end
          if ((b >= MIX_LIM) != ((g - b) < CLOSE_LIM)) return {8'h00, chan_t'(g), chan_t'(b)};
          return {8'h00, quant_level(g), 8'h00};
        end
        if (b > 0) return purple_color(r, b);
        return {quant_level(r), 16'h0000};
      end
      if (b > 0) begin
        if (g > 0) return {8'h00, chan_t'(g), chan_t'(b)};
        return {16'h0000, quant_level(b)};
      end
      if (g > 0) return {8'h00, quant_level(g), 8'h00};
      return BLACK_24;
    endfunction

    function void note_pixel(pixel_t px);
      pending_colors.push_back(palette_color(px));
    endfunction

    function void check_color(pixel_t got);
      pixel_t want;
      if (pending_colors.size() == 0) begin
        $error("led_color: no request waiting, actual %06h", got);
        errors++;
        return;
      end
      want = pending_colors.pop_front();
      if (got !== want) begin
        $error("led_color mismatch: expected %06h, actual %06h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  pixel_t in_pixel_in;
  logic   out_valid;
  logic   out_ready;
  pixel_t out_led_color;

  palette_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  bit stall_armed;
  bit stall_done;

  rgb_to_led_palette_quantizer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_led_color(out_led_color)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  function automatic chan_t clamp_chan(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return chan_t'(v);
  endfunction

  function automatic chan_t edge_value();
    int picks[18] = '{0, 1, 24, 25, 56, 57, 85, 86, 110, 111, 134, 135,
                      165, 166, 220, 221, 254, 255};
    return chan_t'(picks[$urandom_range(17)]);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     base;
    logic [2:0] keep;
    px = pixel_t'($urandom());
    case ($urandom_range(5))
      0: ;
      1: begin
        // Zero out some channels to reach the single and two channel branches.
        keep = 3'($urandom_range(7));
        px = {keep[2] ? px[23:16] : 8'h00, keep[1] ? px[15:8] : 8'h00,
              keep[0] ? px[7:0] : 8'h00};
      end
      2: px = {8'($urandom_range(40)), 8'($urandom_range(40)), 8'($urandom_range(40))};
      3: begin
        base = $urandom_range(255);
        px = {clamp_chan(base + $urandom_range(50) - 25),
              clamp_chan(base + $urandom_range(50) - 25),
              clamp_chan(base + $urandom_range(50) - 25)};
      end
      4: px = {8'($urandom_range(180)), 8'($urandom_range(180)), 8'($urandom_range(180))};
      default: px = {edge_value(), edge_value(), edge_value()};
    endcase
    return px;
  endfunction

  // Result side: ready changes at the falling edge, results are taken at the rising edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_armed && !stall_done) begin
        stall_done = 1'b1;
        repeat (64) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_color(out_led_color);
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    pixel_t directed[$];
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pixel_in = '0;
    tx_idle_pct = 32;
    rx_idle_pct = 71;
    stall_armed = 1'b0;
    stall_done  = 1'b0;
    directed = '{24'h000000, 24'hFFFFFF, 24'h181818, 24'h190000, 24'hACACAE,
                 24'hACACAD, 24'h646464, 24'hC86400, 24'hE60064, 24'hAA0064,
                 24'h780064, 24'h500040, 24'h3200E6, 24'h640064, 24'hDD0000,
                 24'hA60000, 24'h6F0000, 24'h00DC00, 24'h0000FF, 24'h0078C8,
                 24'h283296, 24'h5A3296, 24'h3C1E50, 24'hC8A050, 24'h965064,
                 24'h647832, 24'h8C9628, 24'h329696};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_pixel(directed[i]);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 32; rx_idle_pct = 71; end
        1: begin tx_idle_pct = 71; rx_idle_pct = 32; end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // A long receiver hold while requests keep coming fills the pipeline.
          stall_armed = 1'b1;
        end
      endcase
      repeat (RAND_PER_PHASE) send_pixel(random_pixel());
    end
    in_valid <= 1'b0;

    while (sb.pending_colors.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
